// ===== rtl/copt_pkg.sv =====
// Shared widths, types and constants of the convex polygon overlap test.
package copt_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int IDX_W = $clog2(MAX_VERTICES);

   localparam int IN_W = 16;
   localparam int COORD_W = IN_W + 1;
   localparam int AXIS_W = COORD_W + 1;
   localparam int PROD_W = AXIS_W + COORD_W;
   localparam int DOT_W = PROD_W + 1;

   localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
   localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } vertex_type;

   // One vertex sent into the projection pipeline, tagged with its polygon.
   typedef struct packed {
      logic       valid;
      logic       tag;
      vertex_type vertex;
   } probe_type;

   typedef struct packed {
      logic signed [DOT_W-1:0] a_min;
      logic signed [DOT_W-1:0] a_max;
      logic signed [DOT_W-1:0] b_min;
      logic signed [DOT_W-1:0] b_max;
   } span_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM0,
      ST_NORM1,
      ST_PASS_A,
      ST_PASS_B,
      ST_DRAIN,
      ST_CMP,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/copt_cell.sv =====
// One vertex cell of the rotating vertex chain.
module copt_cell (
   input  logic                 clock,
   input  logic                 shift_en,
   input  copt_pkg::vertex_type vertex_in,
   output copt_pkg::vertex_type vertex_out
);
   import copt_pkg::*;

   vertex_type vertex_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         vertex_ff <= vertex_in;
      end
   end

   assign vertex_out = vertex_ff;

endmodule

// ===== rtl/copt_chain.sv =====
// Vertex chain of one polygon: cells that load at the front and rotate in place.
module copt_chain (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic                      load,
   input  logic                      rotate,
   input  copt_pkg::vertex_type      load_vertex,
   output copt_pkg::vertex_type      head,
   output logic [copt_pkg::CNT_W-1:0] count,
   output logic                      full
);
   import copt_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             shift_en;
   logic [IDX_W-1:0] head_idx;
   vertex_type       feed;
   vertex_type       link [MAX_VERTICES];

   assign full = (count_ff == CNT_W'(MAX_VERTICES));
   assign shift_en = (load && !full) || rotate;
   // The oldest vertex sits in the last occupied cell; rotation feeds it back in front.
   assign head_idx = IDX_W'(count_ff - CNT_W'(1));
   assign head = link[head_idx];
   assign feed = load ? load_vertex : head;

   genvar i;
   generate
      for (i = 0; i < MAX_VERTICES; i++) begin : g_cell
         if (i == 0) begin : g_front
            copt_cell u_cell (
               .clock      (clock),
               .shift_en   (shift_en),
               .vertex_in  (feed),
               .vertex_out (link[i])
            );
         end else begin : g_rest
            copt_cell u_cell (
               .clock      (clock),
               .shift_en   (shift_en),
               .vertex_in  (link[i-1]),
               .vertex_out (link[i])
            );
         end
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (load && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

// ===== rtl/copt_span.sv =====
// Projection pipeline onto the current axis with per-polygon minimum and maximum.
module copt_span (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  copt_pkg::probe_type            probe,
   input  logic signed [copt_pkg::AXIS_W-1:0] axis_x,
   input  logic signed [copt_pkg::AXIS_W-1:0] axis_y,
   output copt_pkg::span_type             span,
   output logic                           busy
);
   import copt_pkg::*;

   logic                     v1_ff, v2_ff;
   logic                     tag1_ff, tag2_ff;
   logic signed [PROD_W-1:0] px_ff, py_ff;
   logic signed [DOT_W-1:0]  dot_ff;
   span_type                 span_ff;
   span_type                 span_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= probe.valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff <= probe.tag;
      px_ff <= PROD_W'(axis_x) * PROD_W'(probe.vertex.x);
      py_ff <= PROD_W'(axis_y) * PROD_W'(probe.vertex.y);
      tag2_ff <= tag1_ff;
      dot_ff <= DOT_W'(px_ff) + DOT_W'(py_ff);
      span_ff <= span_in;
   end

   always_comb begin
      span_in = span_ff;
      if (clear) begin
         span_in.a_min = DOT_MAX;
         span_in.a_max = DOT_MIN;
         span_in.b_min = DOT_MAX;
         span_in.b_max = DOT_MIN;
      end else if (v2_ff) begin
         if (!tag2_ff) begin
            if (dot_ff < span_ff.a_min) span_in.a_min = dot_ff;
            if (dot_ff > span_ff.a_max) span_in.a_max = dot_ff;
         end else begin
            if (dot_ff < span_ff.b_min) span_in.b_min = dot_ff;
            if (dot_ff > span_ff.b_max) span_in.b_max = dot_ff;
         end
      end
   end

   assign span = span_ff;
   assign busy = v1_ff || v2_ff;

endmodule

// ===== rtl/convex_polygon_overlap_test.sv =====
// Top level: vertex loading, separating axis sequencer and result register.
//
//  channel | direction | payload                                   | handshake
//  req     | in        | polygon_select, vertex, offset, last_vertex | req_valid/req_ready
//  rsp     | out       | collide, overflow_error                   | rsp_valid/rsp_ready
//
// Vertices load one per cycle while the sequencer is idle. The word with polygon_select
// high and last_vertex set starts the check, which for each edge of both polygons forms
// the normal, rotates both chains through the projection multipliers, drains and
// compares; input is stalled until the result is in the output register.
// Synchronous reset clears counts, overflow flag, sequencer and rsp_valid.
// A pending result does not block loading of the next pair.
module convex_polygon_overlap_test (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_polygon_select,
   input  logic signed [15:0] req_vertex_x,
   input  logic signed [15:0] req_vertex_y,
   input  logic signed [15:0] req_offset_x,
   input  logic signed [15:0] req_offset_y,
   input  logic        req_last_vertex,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_collide,
   output logic        rsp_overflow_error
);
   import copt_pkg::*;

   state_type state_ff, state_in;
   logic      ovf_ff, ovf_in;
   logic      poly_ff, poly_in;
   logic [CNT_W-1:0] edge_ff, edge_in;
   logic [CNT_W-1:0] vcnt_ff, vcnt_in;
   logic      res_collide_ff, res_collide_in;
   logic      res_ovf_ff, res_ovf_in;
   vertex_type prev_ff, prev_in;
   logic signed [AXIS_W-1:0] axis_x_ff, axis_x_in, axis_y_ff, axis_y_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_collide_ff, rsp_collide_in;
   logic      rsp_ovf_ff, rsp_ovf_in;

   logic       accept;
   logic       load_a, load_b, rotate_a, rotate_b, clear_cnt, span_clear;
   vertex_type new_vertex, head_a, head_b, head_p;
   logic [CNT_W-1:0] count_a, count_b, count_p;
   logic       full_a, full_b, ovf_now, busy, overlap;
   probe_type  probe;
   span_type   span;

   assign new_vertex.x = {req_vertex_x[15], req_vertex_x} + {req_offset_x[15], req_offset_x};
   assign new_vertex.y = {req_vertex_y[15], req_vertex_y} + {req_offset_y[15], req_offset_y};

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign ovf_now = ovf_ff || (req_polygon_select ? full_b : full_a);
   assign head_p = poly_ff ? head_b : head_a;
   assign count_p = poly_ff ? count_b : count_a;
   assign overlap = !(span.a_max < span.b_min) && !(span.b_max < span.a_min);

   copt_chain u_chain_a (
      .clock       (clock),
      .reset       (reset),
      .clear       (clear_cnt),
      .load        (load_a),
      .rotate      (rotate_a),
      .load_vertex (new_vertex),
      .head        (head_a),
      .count       (count_a),
      .full        (full_a)
   );

   copt_chain u_chain_b (
      .clock       (clock),
      .reset       (reset),
      .clear       (clear_cnt),
      .load        (load_b),
      .rotate      (rotate_b),
      .load_vertex (new_vertex),
      .head        (head_b),
      .count       (count_b),
      .full        (full_b)
   );

   copt_span u_span (
      .clock  (clock),
      .reset  (reset),
      .clear  (span_clear),
      .probe  (probe),
      .axis_x (axis_x_ff),
      .axis_y (axis_y_ff),
      .span   (span),
      .busy   (busy)
   );

   always_comb begin
      state_in = state_ff;
      ovf_in = ovf_ff;
      poly_in = poly_ff;
      edge_in = edge_ff;
      vcnt_in = vcnt_ff;
      res_collide_in = res_collide_ff;
      res_ovf_in = res_ovf_ff;
      prev_in = prev_ff;
      axis_x_in = axis_x_ff;
      axis_y_in = axis_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_collide_in = rsp_collide_ff;
      rsp_ovf_in = rsp_ovf_ff;
      load_a = 1'b0;
      load_b = 1'b0;
      rotate_a = 1'b0;
      rotate_b = 1'b0;
      clear_cnt = 1'b0;
      span_clear = 1'b0;
      probe.valid = 1'b0;
      probe.tag = 1'b0;
      probe.vertex = head_a;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load_a = !req_polygon_select;
               load_b = req_polygon_select;
               ovf_in = ovf_now;
               if (req_polygon_select && req_last_vertex) begin
                  poly_in = 1'b0;
                  edge_in = '0;
                  if (ovf_now) begin
                     res_collide_in = 1'b0;
                     res_ovf_in = 1'b1;
                     state_in = ST_FINISH;
                  end else if (count_a == '0) begin
                     // An empty first polygon leaves every second-polygon axis with a gap.
                     res_collide_in = 1'b0;
                     res_ovf_in = 1'b0;
                     state_in = ST_FINISH;
                  end else begin
                     res_ovf_in = 1'b0;
                     state_in = ST_NORM0;
                  end
               end
            end
         end
         ST_NORM0: begin
            // Take vertex i and step the chain so the head is vertex i+1.
            prev_in = head_p;
            rotate_a = !poly_ff;
            rotate_b = poly_ff;
            state_in = ST_NORM1;
         end
         ST_NORM1: begin
            axis_x_in = AXIS_W'(prev_ff.y) - AXIS_W'(head_p.y);
            axis_y_in = AXIS_W'(head_p.x) - AXIS_W'(prev_ff.x);
            span_clear = 1'b1;
            vcnt_in = '0;
            state_in = ST_PASS_A;
         end
         ST_PASS_A: begin
            probe.valid = 1'b1;
            probe.tag = 1'b0;
            probe.vertex = head_a;
            rotate_a = 1'b1;
            if (vcnt_ff + CNT_W'(1) == count_a) begin
               vcnt_in = '0;
               state_in = ST_PASS_B;
            end else begin
               vcnt_in = vcnt_ff + CNT_W'(1);
            end
         end
         ST_PASS_B: begin
            probe.valid = 1'b1;
            probe.tag = 1'b1;
            probe.vertex = head_b;
            rotate_b = 1'b1;
            if (vcnt_ff + CNT_W'(1) == count_b) begin
               vcnt_in = '0;
               state_in = ST_DRAIN;
            end else begin
               vcnt_in = vcnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (!overlap) begin
               res_collide_in = 1'b0;
               state_in = ST_FINISH;
            end else if (edge_ff + CNT_W'(1) == count_p) begin
               if (!poly_ff) begin
                  poly_in = 1'b1;
                  edge_in = '0;
                  state_in = ST_NORM0;
               end else begin
                  res_collide_in = 1'b1;
                  state_in = ST_FINISH;
               end
            end else begin
               edge_in = edge_ff + CNT_W'(1);
               state_in = ST_NORM0;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_collide_in = res_collide_ff;
               rsp_ovf_in = res_ovf_ff;
               clear_cnt = 1'b1;
               ovf_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      poly_ff <= poly_in;
      edge_ff <= edge_in;
      vcnt_ff <= vcnt_in;
      res_collide_ff <= res_collide_in;
      res_ovf_ff <= res_ovf_in;
      prev_ff <= prev_in;
      axis_x_ff <= axis_x_in;
      axis_y_ff <= axis_y_in;
      rsp_collide_ff <= rsp_collide_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_collide = rsp_collide_ff;
   assign rsp_overflow_error = rsp_ovf_ff;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the two-polygon separating axis overlap test.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import copt_pkg::*;

   localparam int RANDOM_WORDS = 1750;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE_CYCLES = 2500;

   typedef struct {
      int x;
      int y;
   } point_type;

   typedef struct packed {
      logic collide;
      logic overflow_error;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_polygon_select = 1'b0;
   logic signed [15:0] req_vertex_x = '0;
   logic signed [15:0] req_vertex_y = '0;
   logic signed [15:0] req_offset_x = '0;
   logic signed [15:0] req_offset_y = '0;
   logic req_last_vertex = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_collide;
   logic rsp_overflow_error;

   // Predictor state: absolute vertices of both polygons and the overflow flag.
   point_type poly_a[MAX_VERTICES];
   point_type poly_b[MAX_VERTICES];
   int count_a = 0;
   int count_b = 0;
   bit overflow_pending = 0;
   verdict_type verdicts[$];

   int fail_count = 0;
   int words_sent = 0;
   int checks_seen = 0;
   int collisions_seen = 0;
   int overflows_seen = 0;
   int cycle_count = 0;
   int burst_left = 0;
   bit gaps_on = 1;
   int hold_len = 0;
   int stall_mode = 0;
   int stall_timer = 0;

   convex_polygon_overlap_test dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver: a stall pattern that changes now and then, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_len != 0) begin
         rsp_ready <= 1'b0;
         hold_len <= hold_len - 1;
      end else begin
         if (stall_timer == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(64, 512);
         end else begin
            stall_timer <= stall_timer - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= (cycle_count % 7) < 2;
            default: rsp_ready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   function automatic bit axis_has_gap(longint nx, longint ny);
      longint lo_a, hi_a, lo_b, hi_b, d;
      lo_a = 64'h7fff_ffff_ffff_ffff;
      hi_a = 64'h8000_0000_0000_0000;
      lo_b = lo_a;
      hi_b = hi_a;
      for (int k = 0; k < count_a; k++) begin
         d = nx * poly_a[k].x + ny * poly_a[k].y;
         if (d < lo_a) lo_a = d;
         if (d > hi_a) hi_a = d;
      end
      for (int k = 0; k < count_b; k++) begin
         d = nx * poly_b[k].x + ny * poly_b[k].y;
         if (d < lo_b) lo_b = d;
         if (d > hi_b) hi_b = d;
      end
      return (hi_a < lo_b) || (hi_b < lo_a);
   endfunction

   function automatic bit edges_overlap(bit second);
      int n, j;
      point_type p, q;
      n = second ? count_b : count_a;
      for (int i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         p = second ? poly_b[i] : poly_a[i];
         q = second ? poly_b[j] : poly_a[j];
         if (axis_has_gap(longint'(p.y) - q.y, longint'(q.x) - p.x)) return 0;
      end
      return 1;
   endfunction

   function automatic void predict_word(bit sel, logic signed [15:0] vx, logic signed [15:0] vy,
                                        logic signed [15:0] ox, logic signed [15:0] oy,
                                        bit last);
      point_type v;
      verdict_type r;
      v.x = int'(vx) + int'(ox);
      v.y = int'(vy) + int'(oy);
      if (!sel && count_a < MAX_VERTICES) begin
         poly_a[count_a] = v;
         count_a++;
      end else if (sel && count_b < MAX_VERTICES) begin
         poly_b[count_b] = v;
         count_b++;
      end else begin
         overflow_pending = 1;
      end
      if (sel && last) begin
         r.overflow_error = overflow_pending;
         r.collide = !overflow_pending && edges_overlap(0) && edges_overlap(1);
         verdicts.push_back(r);
         count_a = 0;
         count_b = 0;
         overflow_pending = 0;
      end
   endfunction

   always @(posedge clock) begin
      verdict_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdicts.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            e = verdicts.pop_front();
            checks_seen++;
            if (e.collide) collisions_seen++;
            if (e.overflow_error) overflows_seen++;
            if (rsp_collide !== e.collide) begin
               $error("collide: expected %0d, got %0d", e.collide, rsp_collide);
               fail_count++;
            end
            if (rsp_overflow_error !== e.overflow_error) begin
               $error("overflow_error: expected %0d, got %0d", e.overflow_error,
                      rsp_overflow_error);
               fail_count++;
            end
         end
      end
   end

   task automatic send_vertex(bit sel, logic signed [15:0] vx, logic signed [15:0] vy,
                              logic signed [15:0] ox, logic signed [15:0] oy, bit last);
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_polygon_select <= sel;
      req_vertex_x <= vx;
      req_vertex_y <= vy;
      req_offset_x <= ox;
      req_offset_y <= oy;
      req_last_vertex <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_word(sel, vx, vy, ox, oy, last);
      words_sent++;
      if (burst_left > 0) burst_left--;
   endtask

   function automatic logic signed [15:0] near(int spread);
      if (spread == 0) return 16'($urandom);
      return 16'(int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // A polygon with vertices scattered around its offset; spread 0 means full range.
   task automatic send_polygon(bit sel, int n, int cx, int cy, int spread, bit mark_last);
      bit last;
      for (int i = 0; i < n; i++) begin
         last = (i == n - 1) ? mark_last : (!sel && $urandom_range(0, 7) == 0);
         if (spread == 0)
            send_vertex(sel, near(0), near(0), near(0), near(0), last);
         else
            send_vertex(sel, near(spread), near(spread), 16'(cx), 16'(cy), last);
      end
   endtask

   task automatic send_square(bit sel, int ox, int oy, bit mark_last);
      send_vertex(sel, 16'sd0, 16'sd0, 16'(ox), 16'(oy), 1'b0);
      send_vertex(sel, 16'sd16, 16'sd0, 16'(ox), 16'(oy), 1'b0);
      send_vertex(sel, 16'sd16, 16'sd16, 16'(ox), 16'(oy), 1'b0);
      send_vertex(sel, 16'sd0, 16'sd16, 16'(ox), 16'(oy), mark_last);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic test_extremes();
      send_vertex(0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
      send_vertex(0, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 0);
      send_vertex(0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1);
      send_vertex(1, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 0);
      send_vertex(1, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 0);
      send_vertex(1, 16'shffff, 16'sh7fff, 16'sh8000, 16'sh0001, 1);
   endtask

   task automatic test_special_cases();
      // Edges that share a line touch and still collide; a shift by one apart does not.
      send_square(0, 0, 0, 1);
      send_square(1, 16, 0, 1);
      send_square(0, 0, 0, 0);
      send_square(1, 17, 0, 1);
      // With no first polygon every second-polygon axis shows a gap.
      send_square(1, 0, 0, 1);
      // Repeated vertices give a zero normal.
      send_vertex(0, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 0);
      send_vertex(0, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 0);
      send_vertex(1, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 1);
   endtask

   task automatic test_overflow();
      send_polygon(0, MAX_VERTICES + 1, 0, 0, 50, 0);
      send_polygon(1, 3, 0, 0, 50, 1);
      send_polygon(0, 3, 0, 0, 50, 0);
      send_polygon(1, MAX_VERTICES + 2, 0, 0, 50, 1);
      // The store is full but not overrun: no overflow.
      send_polygon(0, MAX_VERTICES, 0, 0, 50, 0);
      send_polygon(1, MAX_VERTICES, 0, 0, 50, 1);
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_len <= 3000;
      gaps_on = 0;
      for (int i = 0; i < 6; i++) begin
         send_polygon(0, 3, 0, 0, 40, 0);
         send_polygon(1, 3, 20, 20, 40, 1);
      end
      gaps_on = 1;
      wait_drained();
   endtask

   task automatic test_random();
      int kind, n, cx, cy;
      while (words_sent < RANDOM_WORDS) begin
         kind = $urandom_range(0, 99);
         if ($urandom_range(0, 199) == 0) gaps_on = !gaps_on;
         if (kind < 70) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            cx = $urandom_range(0, 300) - 150;
            cy = $urandom_range(0, 300) - 150;
            send_polygon(0, n, 0, 0, 100, $urandom_range(0, 1));
            send_polygon(1, $urandom_range(1, 6), cx, cy, 100, 1);
         end else if (kind < 80) begin
            send_polygon(0, $urandom_range(1, 5), 0, 0, 0, 0);
            send_polygon(1, $urandom_range(1, 5), 0, 0, 0, 1);
         end else if (kind < 88) begin
            n = $urandom_range(2, 10);
            for (int i = 0; i < n; i++)
               send_vertex($urandom_range(0, 1), near(80), near(80), near(60), near(60),
                           $urandom_range(0, 3) == 0 && i == 0);
            send_vertex(1, near(80), near(80), near(60), near(60), 1);
         end else if (kind < 94) begin
            send_polygon(0, $urandom_range(1, 3), 0, 0, 200, 1);
            send_polygon(1, $urandom_range(1, 3), 0, 0, 200, 0);
         end else begin
            send_polygon($urandom_range(0, 1), MAX_VERTICES + $urandom_range(1, 3), 0, 0,
                         100, 0);
            send_polygon(1, $urandom_range(1, 4), 0, 0, 100, 1);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_special_cases();
      test_overflow();
      test_backpressure();
      test_random();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d vertex words; checked %0d results (%0d collisions, %0d overflows).",
               words_sent, checks_seen, collisions_seen, overflows_seen);
      if (fail_count == 0 && verdicts.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
